FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the UTF-8 decoder; only the top level includes them.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: rtl/u8dec_pkg.sv
// Types and constants of the UTF-8 decoder.
// Used by u8dec_decode, the top level, the checker and the testbench; no dependencies.
`default_nettype none
package u8dec_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd1;

  localparam logic [15:0] CAPACITY_RST = 16'd256;

  localparam logic [7:0] LEAD_1B_MAX = 8'h7F;
  localparam logic [7:0] LEAD_2B_MAX = 8'hDF;
  localparam logic [7:0] LEAD_3B_MAX = 8'hEF;
  localparam logic [7:0] LEAD_4B_MAX = 8'hF7;

  localparam logic [7:0] LATIN_HI_MASK = 8'h1C;
  localparam logic [7:0] LATIN_LO_MASK = 8'h03;
  localparam logic [7:0] LEAD_2B_MASK  = 8'h1F;
  localparam logic [7:0] LEAD_3B_MASK  = 8'h0F;
  localparam logic [7:0] CONT_MASK     = 8'h3F;

  typedef struct packed {
    logic [15:0] partial_code;
    logic [1:0]  bytes_left;
    logic        drop_sequence;
    logic [15:0] emitted_count;
  } state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    logic [15:0] char_count;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/utf8_to_wide_or_latin1_decoder_unit.sv
// UTF-8 string decoder: bytes in, 16-bit or latin-1 characters out.
// Each input byte is registered in the byte register, then decoded into the result register.
// Throughput: one byte per cycle; a skid register holds one extra result, input stalls once both are full.
// Reset (async, active low): mode wide, capacity 256, decode state and buffers empty.
// Depends on u8dec_pkg, u8dec_decode and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module utf8_to_wide_or_latin1_decoder_unit import u8dec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  // source bytes
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] byte_in
  // decoded characters
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [15:0] code_unit, [31:16] char_count
  output logic                 m_axis_tlast    // is_end
);

  logic        mode_q;
  logic [15:0] cap_q;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;

  state_t      st_q, st_d;
  logic        res_valid;
  result_t     res;

  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;

  logic        adv, push, pop, in_xfer;

  assign cfg_ready_o   = 1'b1;
  assign adv           = !skid_valid_q;
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign push          = s1_valid_q && adv && res_valid;
  assign pop           = out_valid_q && m_axis_tready;

  u8dec_decode u_decode (
    .st_i       (st_q),
    .byte_i     (s1_byte_q),
    .latin_i    (mode_q),
    .capacity_i (cap_q),
    .st_o       (st_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cap_q  <= CAPACITY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_MODE:     mode_q <= cfg_data_i[0];
        CFG_IDX_CAPACITY: cap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      st_q         <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (s1_valid_q && adv) st_q <= st_d;
      if (skid_valid_q) begin
        if (pop) skid_valid_q <= 1'b0;
      end else if (push) begin
        if (!out_valid_q || pop) out_valid_q <= 1'b1;
        else skid_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_byte_q <= s_axis_tdata;
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid_q || pop) out_q <= res;
      else skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.char_count, out_q.code_unit};
  assign m_axis_tlast  = out_q.is_end;

  `ASSERT_CLK(a_skid_needs_main, skid_valid_q |-> out_valid_q, "skid full with main empty")
  `ASSERT_NEVER(a_push_into_full, push && skid_valid_q, "result lost: buffer full")
  `ASSERT_CLK(a_end_zero_code, out_valid_q && out_q.is_end |-> out_q.code_unit == 16'd0,
    "end transfer carries nonzero code unit")
  `ASSERT_CLK(a_zero_clears, s1_valid_q && adv && s1_byte_q == 8'd0 |=>
    st_q.emitted_count == 16'd0 && st_q.bytes_left == 2'd0, "zero byte did not clear state")

endmodule
`default_nettype wire

FILE: rtl/u8dec_decode.sv
// Next-state and result logic for one source byte of the UTF-8 decoder.
// Purely combinational; depends on u8dec_pkg.
`default_nettype none
module u8dec_decode import u8dec_pkg::*; (
  input  state_t      st_i,
  input  logic [7:0]  byte_i,
  input  logic        latin_i,
  input  logic [15:0] capacity_i,
  output state_t      st_o,
  output logic        res_valid_o,
  output result_t     res_o
);

  logic [16:0] cnt_inc;
  logic        room;
  logic [15:0] cont_code;
  logic [1:0]  left_dec;

  assign cnt_inc   = {1'b0, st_i.emitted_count} + 17'd1;
  // count < capacity - 1, capacity zero acting as one
  assign room      = cnt_inc < {1'b0, capacity_i};
  assign cont_code = {st_i.partial_code[9:0], 6'd0} | {8'd0, byte_i & CONT_MASK};
  assign left_dec  = st_i.bytes_left - 2'd1;

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '{code_unit: 16'd0, is_end: 1'b0, char_count: cnt_inc[15:0]};
    if (byte_i == 8'd0) begin
      res_valid_o      = 1'b1;
      res_o.is_end     = 1'b1;
      res_o.char_count = st_i.emitted_count;
      st_o             = '0;
    end else if (st_i.bytes_left != 2'd0) begin
      st_o.partial_code = cont_code;
      st_o.bytes_left   = left_dec;
      if (left_dec == 2'd0) begin
        st_o.partial_code  = 16'd0;
        st_o.drop_sequence = 1'b0;
        if (!st_i.drop_sequence) begin
          res_valid_o        = 1'b1;
          res_o.code_unit    = cont_code;
          st_o.emitted_count = cnt_inc[15:0];
        end
      end
    end else if (byte_i <= LEAD_1B_MAX) begin
      if (room) begin
        res_valid_o        = 1'b1;
        res_o.code_unit    = {8'd0, byte_i};
        st_o.emitted_count = cnt_inc[15:0];
      end
    end else if (byte_i <= LEAD_2B_MAX) begin
      st_o.bytes_left = 2'd1;
      if (latin_i) begin
        st_o.partial_code  = {8'd0, byte_i & LATIN_LO_MASK};
        st_o.drop_sequence = ((byte_i & LATIN_HI_MASK) != 8'd0) || !room;
      end else begin
        st_o.partial_code  = {8'd0, byte_i & LEAD_2B_MASK};
        st_o.drop_sequence = !room;
      end
    end else if (byte_i <= LEAD_3B_MAX) begin
      st_o.bytes_left    = 2'd2;
      st_o.partial_code  = {8'd0, byte_i & LEAD_3B_MASK};
      st_o.drop_sequence = latin_i || !room;
    end else if (byte_i <= LEAD_4B_MAX) begin
      st_o.bytes_left    = 2'd3;
      st_o.partial_code  = 16'd0;
      st_o.drop_sequence = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: dv/u8dec_checker.sv
// Scoreboard for the UTF-8 decoder: watches the config, byte and character channels.
// Predicts each character and end item from the accepted bytes and checks the output stream.
// Depends on u8dec_pkg.
module u8dec_checker import u8dec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 src_valid_i,
  input  logic                 src_ready_i,
  input  logic [7:0]           src_byte_i,
  input  logic                 chr_valid_i,
  input  logic                 chr_ready_i,
  input  logic [31:0]          chr_data_i,
  input  logic                 chr_last_i,
  output int unsigned          fail_count_o,
  output int unsigned          open_count_o
);

  logic        latin_mode;
  logic [15:0] capacity;
  logic [15:0] partial;
  logic [1:0]  cont_left;
  logic        drop_char;
  logic [15:0] char_total;

  result_t     due_chars[$];
  int unsigned shown;

  function automatic bit has_room();
    logic [15:0] lim;
    lim = (capacity == '0) ? '0 : capacity - 16'd1;
    return char_total < lim;
  endfunction

  // Returns 1 when the byte completes a character that is kept, or ends the string.
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    bit          emit;
    logic [15:0] value;
    emit  = 1'b0;
    value = '0;
    r     = '0;
    if (b == 8'h00) begin
      r.is_end     = 1'b1;
      r.char_count = char_total;
      partial      = '0;
      cont_left    = '0;
      drop_char    = 1'b0;
      char_total   = '0;
      return 1'b1;
    end
    if (cont_left != '0) begin
      partial   = {partial[9:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == '0) begin
        emit      = !drop_char;
        value     = partial;
        partial   = '0;
        drop_char = 1'b0;
      end
    end else if (b <= LEAD_1B_MAX) begin
      emit  = has_room();
      value = {8'h00, b};
    end else if (b <= LEAD_2B_MAX) begin
      cont_left = 2'd1;
      if (latin_mode) begin
        partial   = {8'h00, b & LATIN_LO_MASK};
        drop_char = ((b & LATIN_HI_MASK) != '0) || !has_room();
      end else begin
        partial   = {8'h00, b & LEAD_2B_MASK};
        drop_char = !has_room();
      end
    end else if (b <= LEAD_3B_MAX) begin
      cont_left = 2'd2;
      partial   = {8'h00, b & LEAD_3B_MASK};
      drop_char = latin_mode || !has_room();
    end else if (b <= LEAD_4B_MAX) begin
      cont_left = 2'd3;
      partial   = '0;
      drop_char = 1'b1;
    end
    if (emit) begin
      char_total   = char_total + 16'd1;
      r.code_unit  = value;
      r.char_count = char_total;
    end
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      latin_mode   = 1'b0;
      capacity     = CAPACITY_RST;
      partial      = '0;
      cont_left    = '0;
      drop_char    = 1'b0;
      char_total   = '0;
      due_chars.delete();
      shown        = 0;
      fail_count_o = 0;
      open_count_o = 0;
    end else begin
      if (chr_valid_i && chr_ready_i) begin
        got.code_unit  = chr_data_i[15:0];
        got.is_end     = chr_last_i;
        got.char_count = chr_data_i[31:16];
        if (due_chars.size() == 0) begin
          fail_count_o++;
          if (shown < 10) begin
            shown++;
            $display("unexpected transfer: code %h end %b count %0d",
                     got.code_unit, got.is_end, got.char_count);
          end
        end else begin
          want = due_chars.pop_front();
          if (got.code_unit !== want.code_unit || got.is_end !== want.is_end ||
              got.char_count !== want.char_count) begin
            fail_count_o++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: code %h/%h end %b/%b count %0d/%0d (expected/actual)",
                       want.code_unit, got.code_unit, want.is_end, got.is_end,
                       want.char_count, got.char_count);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDX_MODE:     latin_mode = cfg_data_i[0];
          CFG_IDX_CAPACITY: capacity = cfg_data_i;
          default: ;
        endcase
      end
      if (src_valid_i && src_ready_i) begin
        if (decode_byte(src_byte_i, fresh)) due_chars.push_back(fresh);
      end
      open_count_o = due_chars.size();
    end
  end

endmodule

FILE: dv/tb.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte and config stimulus, verdict.
// Directed strings, then random strings under several idle, stall and capacity settings.
// Depends on u8dec_pkg, utf8_to_wide_or_latin1_decoder_unit and u8dec_checker.
module tb import u8dec_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
  localparam int unsigned QUIET_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]          cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tlast;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned quiet = 0;

  utf8_to_wide_or_latin1_decoder_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  u8dec_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .src_valid_i(s_axis_tvalid), .src_ready_i(s_axis_tready), .src_byte_i(s_axis_tdata),
    .chr_valid_i(m_axis_tvalid), .chr_ready_i(m_axis_tready),
    .chr_data_i(m_axis_tdata), .chr_last_i(m_axis_tlast),
    .fail_count_o(fail_count), .open_count_o(open_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // sends the n leading bytes of seq, most significant first
  task automatic send_bytes(input logic [31:0] seq, input int n);
    for (int i = 0; i < n; i++) send_byte(seq[31-8*i -: 8]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (open_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic send_char();
    int unsigned k;
    logic [7:0]  lead;
    k = $urandom_range(99);
    if (k < 35) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (k < 60) begin
      lead = 8'($urandom_range(8'h80, 8'hDF));
      if ($urandom_range(1)) lead[4:2] = 3'b000;
      send_byte(lead);
      send_byte(cont_byte());
    end else if (k < 72) begin
      send_byte(8'($urandom_range(8'hE0, 8'hEF)));
      repeat (2) send_byte(cont_byte());
    end else if (k < 80) begin
      send_byte(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) send_byte(cont_byte());
    end else if (k < 86) begin
      send_byte(8'($urandom_range(8'hF8, 8'hFF)));
    end else if (k < 92) begin
      // possibly truncated sequence: terminator may arrive mid-character
      send_byte(8'($urandom_range(8'h80, 8'hF7)));
      if ($urandom_range(1)) send_byte(cont_byte());
      send_byte(8'h00);
    end else begin
      send_byte(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic send_strings(input int unsigned n_bytes);
    int unsigned start;
    int unsigned n_chars;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      n_chars = $urandom_range(12);
      repeat (n_chars) send_char();
      send_byte(8'h00);
    end
  endtask

  task automatic run_phase(input logic latin, input logic [15:0] cap,
                           input int unsigned idle, input int unsigned stall,
                           input int unsigned n_bytes);
    wait_drained();
    write_reg(CFG_IDX_MODE, {15'd0, latin});
    write_reg(CFG_IDX_CAPACITY, cap);
    send_idle_pct = idle;
    stall_pct     = stall;
    send_strings(n_bytes);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: wide, capacity 256
    send_bytes(32'h01_7F_C3_A9, 4);
    send_bytes(32'hDF_BF_EF_BF, 4);
    send_byte(8'hBF);
    send_bytes(32'hF0_9F_98_80, 4);
    send_bytes(32'hF8_FF_80_00, 4);

    // mode switch between lead and continuation keeps the wide decode
    send_byte(8'hC4);
    wait_drained();
    write_reg(CFG_IDX_MODE, 16'd1);
    send_byte(8'h80);
    send_bytes(32'hC3_A9_C4_80, 4);
    send_bytes(32'hE2_82_AC_00, 3);
    send_bytes(32'hC2_FF_00_00, 2);

    // capacity dropped below the count, then zero
    wait_drained();
    write_reg(CFG_IDX_CAPACITY, 16'd1);
    send_bytes(32'h41_00_00_00, 2);
    wait_drained();
    write_reg(CFG_IDX_CAPACITY, 16'd0);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    send_bytes(32'h41_42_00_00, 3);

    run_phase(1'b0, 16'hFFFF, 0, 0, 70);
    run_phase(1'b1, 16'd5, 64, 0, 70);
    run_phase(1'b0, 16'd3, 0, 64, 70);
    run_phase(1'b1, 16'hFFFF, 15, 15, 70);

    // long receiver hold-off while bytes keep coming
    wait_drained();
    write_reg(CFG_IDX_MODE, 16'd0);
    write_reg(CFG_IDX_CAPACITY, CAPACITY_RST);
    send_idle_pct = 0;
    stall_pct     = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off <= 1'b0;
      end
      send_strings(40);
    join
    wait_drained();
    send_strings(30);

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: utf8_to_wide_or_latin1_decoder_unit.f
+incdir+rtl
rtl/u8dec_pkg.sv
rtl/u8dec_decode.sv
rtl/utf8_to_wide_or_latin1_decoder_unit.sv
dv/u8dec_checker.sv
dv/tb.sv
